/* rtl/core/etrp_pkg.sv */
// shared types, character codes and helpers for the escaped tsv record parser
package etrp_pkg;

   // default number of fields a record must carry
   localparam int FIELDS_PER_RECORD_DEF = 4;

   // character codes
   localparam logic [7:0] CHAR_NL  = 8'h0A;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_BSL = 8'h5C;
   localparam logic [7:0] CHAR_N   = 8'h6E;
   localparam logic [7:0] CHAR_T   = 8'h74;

   // result word kinds
   typedef enum logic [1:0] {
      KIND_DATA        = 2'd0,
      KIND_FIELD_END   = 2'd1,
      KIND_RECORD_END  = 2'd2,
      KIND_END_OF_DATA = 2'd3
   } kind_type;

   // record and overall status codes
   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_FIELD_COUNT = 2'd1,
      ST_BAD_ESCAPE  = 2'd2
   } status_type;

   // one result word
   typedef struct packed {
      kind_type   kind;
      logic [7:0] decoded_byte;
      logic [2:0] field_number;
      status_type status;
      logic       last_result;
   } rsp_type;

   // up to two result words caused by one input word, packed from slot a
   typedef struct packed {
      logic [1:0] count;
      rsp_type    a;
      rsp_type    b;
   } rsp_pair_type;

   // status of the open line: field count is checked before escapes
   function automatic status_type line_status(input logic [2:0] tabs,
                                              input logic       esc_err,
                                              input logic       esc_pend,
                                              input logic [2:0] fields);
      status_type st;
      st = ST_OK;
      if (({1'b0, tabs} + 4'd1) != {1'b0, fields}) begin
         st = ST_FIELD_COUNT;
      end else if (esc_err || esc_pend) begin
         st = ST_BAD_ESCAPE;
      end
      return st;
   endfunction

endpackage

/* rtl/core/etrp_step.sv */
// input register, line state and one-word parse step
module etrp_step #(
   parameter int FIELDS_PER_RECORD = etrp_pkg::FIELDS_PER_RECORD_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_text_byte,
   input  logic                  req_final_byte,
   input  logic [1:0]            buf_level,
   output logic                  push,
   output etrp_pkg::rsp_pair_type pair
);

   localparam logic [2:0] FieldLim = 3'(FIELDS_PER_RECORD);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_final_ff;

   // line state
   logic                 esc_pend_ff, esc_pend_in;
   logic                 has_content_ff, has_content_in;
   logic [2:0]           tab_count_ff, tab_count_in;
   logic                 esc_err_ff, esc_err_in;
   etrp_pkg::status_type sticky_ff, sticky_in;

   logic                 part_valid;
   etrp_pkg::rsp_type    part_rsp;
   etrp_pkg::rsp_type    end_rsp;
   etrp_pkg::status_type line_st;
   etrp_pkg::status_type end_st;
   logic [2:0]           field_idx;
   logic                 adv;

   // field index saturated at the expected field count
   assign field_idx = (tab_count_ff < FieldLim) ? tab_count_ff : FieldLim;
   assign line_st   = etrp_pkg::line_status(tab_count_ff, esc_err_ff, esc_pend_ff, FieldLim);

   // parse step on the registered word
   always_comb begin
      esc_pend_in    = esc_pend_ff;
      has_content_in = has_content_ff;
      tab_count_in   = tab_count_ff;
      esc_err_in     = esc_err_ff;
      sticky_in      = sticky_ff;
      part_valid     = 1'b0;
      part_rsp       = '{etrp_pkg::KIND_DATA, 8'd0, field_idx, etrp_pkg::ST_OK, 1'b0};
      if (sticky_ff == etrp_pkg::ST_OK) begin
         if (in_byte_ff == etrp_pkg::CHAR_NL) begin
            if (has_content_ff) begin
               part_valid     = 1'b1;
               part_rsp.kind  = etrp_pkg::KIND_RECORD_END;
               part_rsp.status = line_st;
               esc_pend_in    = 1'b0;
               has_content_in = 1'b0;
               tab_count_in   = 3'd0;
               esc_err_in     = 1'b0;
               sticky_in      = line_st;
            end
         end else begin
            has_content_in = 1'b1;
            if (esc_pend_ff) begin
               esc_pend_in = 1'b0;
               case (in_byte_ff)
                  etrp_pkg::CHAR_N: begin
                     part_valid            = 1'b1;
                     part_rsp.decoded_byte = etrp_pkg::CHAR_NL;
                  end
                  etrp_pkg::CHAR_T: begin
                     part_valid            = 1'b1;
                     part_rsp.decoded_byte = etrp_pkg::CHAR_TAB;
                  end
                  etrp_pkg::CHAR_BSL: begin
                     part_valid            = 1'b1;
                     part_rsp.decoded_byte = etrp_pkg::CHAR_BSL;
                  end
                  default: begin
                     esc_err_in = 1'b1;
                     if (in_byte_ff == etrp_pkg::CHAR_TAB) begin
                        part_valid    = 1'b1;
                        part_rsp.kind = etrp_pkg::KIND_FIELD_END;
                        if (tab_count_ff != 3'd7) begin
                           tab_count_in = tab_count_ff + 3'd1;
                        end
                     end
                  end
               endcase
            end else if (in_byte_ff == etrp_pkg::CHAR_BSL) begin
               esc_pend_in = 1'b1;
            end else if (in_byte_ff == etrp_pkg::CHAR_TAB) begin
               part_valid    = 1'b1;
               part_rsp.kind = etrp_pkg::KIND_FIELD_END;
               if (tab_count_ff != 3'd7) begin
                  tab_count_in = tab_count_ff + 3'd1;
               end
            end else begin
               part_valid            = 1'b1;
               part_rsp.decoded_byte = in_byte_ff;
            end
         end
      end
      // end-of-data status from the state after this word
      if (sticky_in != etrp_pkg::ST_OK) begin
         end_st = sticky_in;
      end else if (has_content_in) begin
         end_st = etrp_pkg::line_status(tab_count_in, esc_err_in, esc_pend_in, FieldLim);
      end else begin
         end_st = etrp_pkg::ST_OK;
      end
      end_rsp = '{etrp_pkg::KIND_END_OF_DATA, 8'd0, 3'd0, end_st, 1'b1};
      // final word returns everything to the reset state
      if (in_final_ff) begin
         esc_pend_in    = 1'b0;
         has_content_in = 1'b0;
         tab_count_in   = 3'd0;
         esc_err_in     = 1'b0;
         sticky_in      = etrp_pkg::ST_OK;
      end
   end

   // result pair, packed from the first slot
   always_comb begin
      pair.count = {1'b0, part_valid} + {1'b0, in_final_ff};
      pair.a     = part_valid ? part_rsp : end_rsp;
      pair.b     = end_rsp;
   end

   // advance when the result queue has room for every word of this item
   assign adv       = in_valid_ff && (({1'b0, buf_level} + {1'b0, pair.count}) <= 3'd2);
   assign push      = adv;
   assign req_ready = !in_valid_ff || adv;

   // input register valid
   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (adv) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // state and input registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         esc_pend_ff    <= 1'b0;
         has_content_ff <= 1'b0;
         tab_count_ff   <= 3'd0;
         esc_err_ff     <= 1'b0;
         sticky_ff      <= etrp_pkg::ST_OK;
      end else begin
         in_valid_ff <= in_valid_in;
         if (adv) begin
            esc_pend_ff    <= esc_pend_in;
            has_content_ff <= has_content_in;
            tab_count_ff   <= tab_count_in;
            esc_err_ff     <= esc_err_in;
            sticky_ff      <= sticky_in;
         end
      end
   end

   // input payload register
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_text_byte;
         in_final_ff <= req_final_byte;
      end
   end

`ifndef ASSERT_OFF
   // a final word leaves the parser in its reset state
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (adv && in_final_ff) |=> (sticky_ff == etrp_pkg::ST_OK && !has_content_ff
                                && tab_count_ff == 3'd0 && !esc_pend_ff && !esc_err_ff))
      else $error("parser state not cleared after final word");
   // once an error is sticky, only a final word may produce results
   a_drop_after_error: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && sticky_ff != etrp_pkg::ST_OK) |-> (pair.count == {1'b0, in_final_ff}))
      else $error("result produced while dropping after an error");
`endif

endmodule

/* rtl/core/etrp_rsp_buf.sv */
// two-word result queue that drains one word per cycle while rsp_ready is high
module etrp_rsp_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  etrp_pkg::rsp_pair_type pair,
   output logic [1:0]             level,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output etrp_pkg::rsp_type      head
);

   logic [1:0]        cnt_ff, cnt_in;
   etrp_pkg::rsp_type q_ff [2];
   etrp_pkg::rsp_type q_in [2];
   logic [1:0]        keep;
   logic [1:0]        push_n;
   logic              pop;

   assign pop       = (cnt_ff != 2'd0) && rsp_ready;
   assign push_n    = push ? pair.count : 2'd0;
   assign level     = cnt_ff;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign head      = q_ff[0];

   // shift out the head, then append the new words behind what stays
   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      keep    = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         keep    = cnt_ff - 2'd1;
      end
      if (push_n != 2'd0) begin
         q_in[keep[0]] = pair.a;
      end
      if (push_n == 2'd2) begin
         q_in[1] = pair.b;
      end
      cnt_in = keep + push_n;
   end

   // queue fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // queue entries
   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

`ifndef ASSERT_OFF
   // the producer never pushes more words than the queue can hold
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (({1'b0, cnt_ff} + {1'b0, pair.count}) <= 3'd2))
      else $error("result queue overflow");
   // a waiting end-of-data word is always the last one of the data
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((head.kind == etrp_pkg::KIND_END_OF_DATA) == head.last_result))
      else $error("last flag and end-of-data kind disagree");
`endif

endmodule

/* rtl/core/escaped_tsv_record_parser_core.sv */
// top level of the escaped tab-separated record parser
// Parses one text byte per word and per cycle: an accepted word is held in an input register,
// decoded against the line state in the next cycle and written to a two-entry result queue, whose
// head offers the result words in order. A word causes zero, one or two result words; the queue
// takes a word's results only when it has room for all of them, which with rsp_ready high allows
// a new word every cycle for words with at most one result. A word with the final flag and a
// parsed result yields two result words; behind a waiting result word it stalls until the queue
// is empty, and the word after it then waits for the queue to drain to one entry. Records must
// carry FIELDS_PER_RECORD fields (1 to 7).
module escaped_tsv_record_parser_core #(
   parameter int FIELDS_PER_RECORD = etrp_pkg::FIELDS_PER_RECORD_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_decoded_byte,
   output logic [2:0] rsp_field_number,
   output logic [1:0] rsp_status,
   output logic       rsp_last_result
);

   logic                   push;
   logic [1:0]             level;
   etrp_pkg::rsp_pair_type pair;
   etrp_pkg::rsp_type      head;

   // parse step with input register and line state
   etrp_step #(
      .FIELDS_PER_RECORD(FIELDS_PER_RECORD)
   ) u_step (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_text_byte  (req_text_byte),
      .req_final_byte (req_final_byte),
      .buf_level      (level),
      .push           (push),
      .pair           (pair)
   );

   // result queue
   etrp_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pair      (pair),
      .level     (level),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   // result word fields
   assign rsp_kind         = head.kind;
   assign rsp_decoded_byte = head.decoded_byte;
   assign rsp_field_number = head.field_number;
   assign rsp_status       = head.status;
   assign rsp_last_result  = head.last_result;

endmodule
